/* hdl/ipwb_pkg.sv */
// Shared types and constants for the integer power unit with interval bounds.
// No dependencies; used by ipwb_pow and integer_power_with_interval_bounds.
`timescale 1ns / 1ps

package ipwb_pkg;

    localparam int DATA_WIDTH = 64;

    // Largest positive result magnitude, and the most negative result sign-extended to 64 bits.
    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF >> (64 - DATA_WIDTH);
    localparam logic [63:0] NEG_MIN = ~POS_MAX;

    localparam logic ACT_EVAL   = 1'b0;
    localparam logic ACT_BOUNDS = 1'b1;

    // Status from the power unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } t_pow_rsp;

endpackage

/* hdl/ipwb_pow.sv */
// Saturating signed integer power, one 32x32 multiplier reused for every product.
// Depends on ipwb_pkg.
`timescale 1ns / 1ps

module ipwb_pow (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [63:0]   i_base,
    input  logic signed [63:0]   i_exp,
    output ipwb_pkg::t_pow_rsp   o_rsp,
    output logic signed [63:0]   o_value
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DONE} t_state;

    t_state        r_state;
    logic [63:0]   r_mag;
    logic [63:0]   r_acc;
    logic [5:0]    r_cnt;
    logic          r_neg;
    logic [2:0]    r_ph;
    logic [63:0]   r_pp;
    logic [1:0]    r_sh;
    logic [127:0]  r_prod;
    logic          r_sat;
    logic signed [63:0] r_value;

    logic [63:0]  start_mag;
    logic         start_neg;
    logic [127:0] limit;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [127:0] pp_shifted;

    assign start_mag = i_base[63] ? (64'd0 - i_base) : i_base;
    assign start_neg = i_base[63] & i_exp[0];
    assign limit     = {64'd0, ipwb_pkg::POS_MAX} + {127'd0, r_neg};

    assign mul_a = r_ph[1] ? r_acc[63:32] : r_acc[31:0];
    assign mul_b = r_ph[0] ? r_mag[63:32] : r_mag[31:0];
    assign pp_shifted = {64'd0, r_pp} << (7'd32 * {5'd0, r_sh});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sat   <= 1'b0;
            r_ph    <= 3'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sat   <= 1'b0;
                        r_mag   <= start_mag;
                        r_neg   <= start_neg;
                        r_acc   <= 64'd1;
                        r_cnt   <= i_exp[5:0];
                        r_ph    <= 3'd0;
                        r_state <= S_DONE;
                        if (i_exp[63]) begin
                            // Negative exponent: truncated quotient.
                            if (i_base == 64'sd1)
                                r_value <= 64'sd1;
                            else if (i_base == -64'sd1)
                                r_value <= i_exp[0] ? -64'sd1 : 64'sd1;
                            else
                                r_value <= 64'sd0;
                        end else if (i_exp == 64'sd0) begin
                            r_value <= 64'sd1;
                        end else if (start_mag == 64'd0) begin
                            r_value <= 64'sd0;
                        end else if (start_mag == 64'd1) begin
                            r_value <= start_neg ? -64'sd1 : 64'sd1;
                        end else if (i_exp[62:6] != 57'd0) begin
                            r_sat   <= 1'b1;
                            r_value <= start_neg ? ipwb_pkg::NEG_MIN : ipwb_pkg::POS_MAX;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // Phases 0-3 form partial products, 1-4 sum them, 5 checks the range.
                    if (r_ph <= 3'd3) begin
                        r_pp <= 64'(mul_a * mul_b);
                        r_sh <= 2'({1'b0, r_ph[1]} + {1'b0, r_ph[0]});
                    end
                    if (r_ph >= 3'd1 && r_ph <= 3'd4)
                        r_prod <= ((r_ph == 3'd1) ? 128'd0 : r_prod) + pp_shifted;
                    if (r_ph == 3'd5) begin
                        r_ph <= 3'd0;
                        if (r_prod > limit) begin
                            r_sat   <= 1'b1;
                            r_value <= r_neg ? ipwb_pkg::NEG_MIN : ipwb_pkg::POS_MAX;
                            r_state <= S_DONE;
                        end else begin
                            r_acc <= r_prod[63:0];
                            r_cnt <= r_cnt - 6'd1;
                            if (r_cnt == 6'd1) begin
                                r_value <= r_neg ? (64'sd0 - $signed(r_prod[63:0]))
                                                 : $signed(r_prod[63:0]);
                                r_state <= S_DONE;
                            end
                        end
                    end else begin
                        r_ph <= r_ph + 3'd1;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.busy = (r_state != S_IDLE);
    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.sat  = r_sat;
    assign o_value    = r_value;

endmodule

/* hdl/integer_power_with_interval_bounds.sv */
// Channel   Direction  Handshake            Beat contents
// input     in         i_valid / o_stall    action, base, exponent, base/exp intervals
// output    out        o_valid / i_stall    power value, bound low/high, saturated
//
// Each multiply uses the shared 32x32 multiplier in ipwb_pow, one multiply per exponent
// step (up to 63). An evaluate beat passes through S_JOB, S_WAIT and S_FIN before its
// result is valid at the output; the input is free in the same cycle. A bounds beat runs
// up to six powers one after another, each through S_JOB and S_WAIT, or S_JOB alone when
// a power is skipped, then S_ZADJ for the zero adjustment and S_FIN for the output load.
// Reset is synchronous and active low; it clears the replacement sign to plus one.
// Input is stalled from acceptance until the result is loaded into the output register.
// Top-level sequencer; depends on ipwb_pkg and ipwb_pow.
`timescale 1ns / 1ps

module integer_power_with_interval_bounds (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic signed [63:0] i_base,
    input  logic signed [63:0] i_exponent,
    input  logic signed [63:0] i_base_low,
    input  logic signed [63:0] i_base_high,
    input  logic signed [63:0] i_exp_low,
    input  logic signed [63:0] i_exp_high,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [63:0] o_power_value,
    output logic signed [63:0] o_bound_low,
    output logic signed [63:0] o_bound_high,
    output logic               o_saturated
);

    typedef enum logic [2:0] {S_IDLE, S_JOB, S_WAIT, S_ZADJ, S_FIN} t_state;

    t_state             r_state;
    logic               r_act;
    logic signed [63:0] r_xl, r_xu, r_yl, r_yu;
    logic signed [63:0] r_pv, r_lo, r_hi;
    logic               r_sat;
    logic               r_zsn;
    logic [2:0]         r_k;
    logic               r_valid;

    logic signed [63:0] job_base, job_exp;
    logic               need_pow;
    logic               pu_start;
    ipwb_pkg::t_pow_rsp pu_rsp;
    logic signed [63:0] pu_value;
    logic signed [63:0] n_lo, n_hi;

    function automatic logic signed [63:0] f_min(logic signed [63:0] a, logic signed [63:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic signed [63:0] f_max(logic signed [63:0] a, logic signed [63:0] b);
        return (b > a) ? b : a;
    endfunction

    always_comb begin
        job_base = r_xl;
        job_exp  = r_yl;
        need_pow = 1'b0;
        n_lo     = r_lo;
        n_hi     = r_hi;
        if (r_act == ipwb_pkg::ACT_EVAL) begin
            need_pow = 1'b1;
            if (r_xl == 64'sd0 && r_yl < 64'sd0)
                job_base = r_zsn ? -64'sd1 : 64'sd1;
        end else begin
            case (r_k)
                3'd0: begin job_base = r_xl; job_exp = r_yl; end
                3'd1: begin job_base = r_xl; job_exp = r_yu; end
                3'd2: begin job_base = r_xu; job_exp = r_yl; end
                3'd3: begin job_base = r_xu; job_exp = r_yu; end
                3'd4: begin job_base = r_xl; job_exp = r_yu - 64'sd1; end
                default: begin job_base = r_xl; job_exp = r_yu; end
            endcase
            if (r_k <= 3'd3) begin
                need_pow = (job_base != 64'sd0) || (job_exp >= 64'sd0);
                // A zero corner with a negative exponent stands in for its nonzero neighbors.
                if (!need_pow) begin
                    if (r_xl < 64'sd0) begin
                        n_lo = f_min(n_lo, job_exp[0] ? -64'sd1 : 64'sd1);
                        n_hi = f_max(n_hi, job_exp[0] ? -64'sd1 : 64'sd1);
                    end
                    if (r_xu > 64'sd0) begin
                        n_lo = f_min(n_lo, 64'sd1);
                        n_hi = f_max(n_hi, 64'sd1);
                    end
                end
            end else begin
                need_pow = (r_xl < 64'sd0) && (r_yu >= 64'sd2);
            end
        end
    end

    assign pu_start = (r_state == S_JOB) && need_pow;

    ipwb_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pu_start),
        .i_base  (job_base),
        .i_exp   (job_exp),
        .o_rsp   (pu_rsp),
        .o_value (pu_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_zsn   <= 1'b0;
            r_valid <= 1'b0;
            r_k     <= 3'd0;
        end else begin
            // In S_FIN the output register is reloaded instead.
            if (r_valid && !i_stall && r_state != S_FIN)
                r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_act <= i_action;
                        r_pv  <= 64'sd0;
                        r_sat <= 1'b0;
                        r_k   <= 3'd0;
                        r_xu  <= i_base_high;
                        r_yu  <= i_exp_high;
                        if (i_action == ipwb_pkg::ACT_EVAL) begin
                            r_xl <= i_base;
                            r_yl <= i_exponent;
                            r_lo <= 64'sd0;
                            r_hi <= 64'sd0;
                        end else begin
                            r_xl <= i_base_low;
                            r_yl <= i_exp_low;
                            r_lo <= 64'sh7FFF_FFFF_FFFF_FFFF;
                            r_hi <= 64'sh8000_0000_0000_0000;
                        end
                        r_state <= S_JOB;
                    end
                end
                S_JOB: begin
                    if (need_pow) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_lo <= n_lo;
                        r_hi <= n_hi;
                        r_k  <= r_k + 3'd1;
                        if (r_k == 3'd5)
                            r_state <= S_ZADJ;
                    end
                end
                S_WAIT: begin
                    if (pu_rsp.done) begin
                        r_sat <= r_sat | pu_rsp.sat;
                        if (r_act == ipwb_pkg::ACT_EVAL) begin
                            r_pv    <= pu_value;
                            r_state <= S_FIN;
                        end else begin
                            r_lo    <= f_min(r_lo, pu_value);
                            r_hi    <= f_max(r_hi, pu_value);
                            r_k     <= r_k + 3'd1;
                            r_state <= (r_k == 3'd5) ? S_ZADJ : S_JOB;
                        end
                    end
                end
                S_ZADJ: begin
                    r_zsn <= 1'b0;
                    if (r_xl <= 64'sd0 && r_xu >= 64'sd0) begin
                        if (r_yl < 64'sd0) begin
                            r_lo <= f_min(r_lo, (r_xl < 64'sd0) ? -64'sd1 : 64'sd0);
                            r_hi <= f_max(r_hi, 64'sd1);
                            r_zsn <= (r_xu == 64'sd0);
                        end else begin
                            r_lo <= f_min(r_lo, 64'sd0);
                            r_hi <= f_max(r_hi, 64'sd0);
                        end
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_valid || !i_stall) begin
                        o_power_value <= r_pv;
                        o_bound_low   <= r_lo;
                        o_bound_high  <= r_hi;
                        o_saturated   <= r_sat;
                        r_valid       <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // The power unit is only started when it is free.
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pu_start |-> !pu_rsp.busy) else $error("power unit started while busy");

    // An accepted beat keeps the input stalled on the next cycle.
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("input not stalled after accept");

    // Bounds are ordered for both actions.
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bound_low <= o_bound_high)) else $error("bounds out of order");

    // An evaluate result with a nonzero value carries zero bounds.
    a_eval_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_power_value != 64'sd0) |-> (o_bound_low == 64'sd0 && o_bound_high == 64'sd0))
        else $error("evaluate result with nonzero bounds");

endmodule
